/* sv/clcd_pkg.sv */
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, codes and command builders for the character LCD controller.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int BUFFER_DEPTH_DEF     = 64;
  localparam int POWER_ON_WAIT_MS_DEF = 36;

  localparam logic [7:0] CLEAR_DISPLAY_CMD = 8'h01;

  typedef enum logic [1:0] {
    PH_OFF,
    PH_INIT,
    PH_OPER
  } phase_t;

  typedef enum logic [2:0] {
    IS_WAIT,
    IS_FUNC,
    IS_DISP,
    IS_CLEAR,
    IS_ENTRY,
    IS_END
  } init_step_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_INIT,
    CMD_LOAD,
    CMD_WRITE
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_FOUR_BIT,
    CFG_FUNCTION,
    CFG_DISPLAY,
    CFG_ENTRY,
    CFG_TICK
  } cfg_reg_t;

  typedef struct packed {
    logic       four_bit_mode;
    logic [1:0] function_flags;
    logic [2:0] display_flags;
    logic [1:0] entry_flags;
    logic [5:0] tick_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [6:0] str_length;
    logic [7:0] buf_byte;
    logic [5:0] buf_index;
    logic [1:0] cmd;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       ready_res;
    logic       busy_res;
    logic [7:0] data_pins;
    logic       enable_pin;
    logic       reg_select;
  } result_t;

  function automatic logic [7:0] function_set_byte(logic four, logic [1:0] flags);
    function_set_byte = {3'b001, ~four, flags, 2'b00};
  endfunction

  function automatic logic [7:0] display_ctrl_byte(logic [2:0] flags);
    display_ctrl_byte = {5'b00001, flags};
  endfunction

  function automatic logic [7:0] entry_mode_byte(logic [1:0] flags);
    entry_mode_byte = {6'b000001, flags};
  endfunction

endpackage

/* sv/clcd_buf.sv */
// ----------------------------------------------------------------------------
// clcd_buf
// Character buffer: one write port, one registered read port with bypass of
// a same-cycle write to the address being read.
// ----------------------------------------------------------------------------
module clcd_buf
  import clcd_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int AW           = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

/* sv/clcd_core.sv */
// ----------------------------------------------------------------------------
// clcd_core
// Sequencer state and next-state logic: power-on wait, init command bytes,
// string printing and enable toggling, one transaction per step.
// ----------------------------------------------------------------------------
module clcd_core
  import clcd_pkg::*;
#(
  parameter int BUFFER_DEPTH     = BUFFER_DEPTH_DEF,
  parameter int POWER_ON_WAIT_MS = POWER_ON_WAIT_MS_DEF,
  parameter int AW               = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
  parameter int LW               = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  item_t         item,
  input  logic          step_en,
  input  logic [7:0]    rd_data,
  output logic [AW-1:0] rd_addr,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output result_t       result
);

  phase_t        phase, phase_next;
  init_step_t    init_step, init_step_next;
  logic [7:0]    step_counter, step_counter_next;
  logic          enable_level, enable_level_next;
  logic          nibble_high, nibble_high_next;
  logic          rs_level, rs_level_next;
  logic [7:0]    data_latch, data_latch_next;
  logic          busy_flag, busy_flag_next;
  logic [LW-1:0] write_length, write_length_next;
  logic [LW-1:0] write_index, write_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_OFF;
      init_step    <= IS_WAIT;
      step_counter <= '0;
      enable_level <= 1'b0;
      nibble_high  <= 1'b1;
      rs_level     <= 1'b0;
      data_latch   <= '0;
      busy_flag    <= 1'b0;
      write_length <= '0;
      write_index  <= '0;
    end else if (step_en) begin
      phase        <= phase_next;
      init_step    <= init_step_next;
      step_counter <= step_counter_next;
      enable_level <= enable_level_next;
      nibble_high  <= nibble_high_next;
      rs_level     <= rs_level_next;
      data_latch   <= data_latch_next;
      busy_flag    <= busy_flag_next;
      write_length <= write_length_next;
      write_index  <= write_index_next;
    end
  end

  always_comb begin
    logic [2:0] toggles;
    logic [8:0] wait_sum;
    logic [7:0] wait_sat;
    logic [7:0] count_inc;
    logic       do_toggle;
    logic       tog_rs;
    logic [7:0] tog_byte;
    logic       in_range;
    logic       accepted;

    toggles   = cfg.four_bit_mode ? 3'd4 : 3'd2;
    wait_sum  = {1'b0, step_counter} + {3'b000, cfg.tick_period_ms};
    wait_sat  = wait_sum[8] ? 8'hFF : wait_sum[7:0];
    count_inc = step_counter + 8'd1;
    do_toggle = 1'b0;
    tog_rs    = 1'b0;
    tog_byte  = '0;
    in_range  = ({3'b000, item.buf_index} < 9'(BUFFER_DEPTH));
    accepted  = 1'b0;

    phase_next        = phase;
    init_step_next    = init_step;
    step_counter_next = step_counter;
    enable_level_next = enable_level;
    nibble_high_next  = nibble_high;
    rs_level_next     = rs_level;
    data_latch_next   = data_latch;
    busy_flag_next    = busy_flag;
    write_length_next = write_length;
    write_index_next  = write_index;
    wr_en             = 1'b0;

    case (cmd_t'(item.cmd))
      CMD_TICK: begin
        if (phase == PH_INIT) begin
          case (init_step)
            IS_WAIT: begin
              if (wait_sat >= 8'(POWER_ON_WAIT_MS)) begin
                init_step_next    = IS_FUNC;
                step_counter_next = '0;
              end else begin
                step_counter_next = wait_sat;
              end
            end
            IS_FUNC, IS_DISP, IS_CLEAR, IS_ENTRY: begin
              do_toggle = 1'b1;
              case (init_step)
                IS_FUNC:  tog_byte = function_set_byte(cfg.four_bit_mode, cfg.function_flags);
                IS_DISP:  tog_byte = display_ctrl_byte(cfg.display_flags);
                IS_CLEAR: tog_byte = CLEAR_DISPLAY_CMD;
                default:  tog_byte = entry_mode_byte(cfg.entry_flags);
              endcase
              if (count_inc >= {5'b00000, toggles}) begin
                init_step_next    = init_step_t'(init_step + 3'd1);
                step_counter_next = '0;
              end else begin
                step_counter_next = count_inc;
              end
            end
            default: begin
              phase_next = PH_OPER;
            end
          endcase
        end else if (phase == PH_OPER) begin
          if (write_index < write_length) begin
            do_toggle = 1'b1;
            tog_rs    = 1'b1;
            tog_byte  = rd_data;
            if (count_inc >= {5'b00000, toggles}) begin
              write_index_next  = write_index + LW'(1);
              step_counter_next = '0;
            end else begin
              step_counter_next = count_inc;
            end
          end else begin
            busy_flag_next = 1'b0;
          end
        end
      end
      CMD_INIT: begin
        if (phase == PH_OFF) begin
          phase_next        = PH_INIT;
          enable_level_next = 1'b0;
        end
      end
      CMD_LOAD: begin
        wr_en = in_range;
      end
      default: begin
        if (!busy_flag) begin
          busy_flag_next    = 1'b1;
          write_length_next = ({2'b00, item.str_length} > 9'(BUFFER_DEPTH)) ?
                              LW'(BUFFER_DEPTH) : LW'(item.str_length);
          write_index_next  = '0;
          accepted          = 1'b1;
        end
      end
    endcase

    if (do_toggle) begin
      rs_level_next = tog_rs;
      if (!enable_level) begin
        if (cfg.four_bit_mode) begin
          data_latch_next = nibble_high ? {4'h0, tog_byte[7:4]} : {4'h0, tog_byte[3:0]};
        end else begin
          data_latch_next = tog_byte;
        end
        enable_level_next = 1'b1;
      end else begin
        enable_level_next = 1'b0;
        if (cfg.four_bit_mode) begin
          nibble_high_next = ~nibble_high;
        end
      end
    end

    result.reg_select = rs_level_next;
    result.enable_pin = enable_level_next;
    result.data_pins  = data_latch_next;
    result.busy_res   = busy_flag_next;
    result.ready_res  = (phase_next == PH_OPER);
    result.accepted   = accepted;
  end

  assign wr_addr = AW'(item.buf_index);
  assign wr_data = item.buf_byte;
  assign rd_addr = step_en ? AW'(write_index_next) : AW'(write_index);

`ifndef SYNTHESIS
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    write_index <= write_length)
    else $error("write index ran past string length");

  a_oper_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_OPER |=> phase == PH_OPER)
    else $error("left operation phase");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    init_step != IS_WAIT |-> step_counter < 8'd4)
    else $error("toggle counter out of range after power-on wait");
`endif

endmodule

/* sv/char_lcd_tick_controller.sv */
// ----------------------------------------------------------------------------
// char_lcd_tick_controller
// Tick-driven HD44780-style character LCD controller.
//
// Items arrive on the s_ stream: a tick, a start-init, a buffer load or a
// string write request. Every transaction produces exactly one result on the
// m_ stream carrying the RS, E and data pin levels, busy, ready and whether
// a write request was taken. Configuration registers are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while the
// stream is idle, which the block itself does not enforce. A taken item is
// registered with its buffer read in the working stage, then its result in
// the output register. Throughput: one item per clock while m_tready is
// high; the buffer read for the next item is addressed with the forwarded
// string index, and a load to the same entry in the same cycle is bypassed.
// Reset: the sequencer returns to off with E low, busy and ready clear, and
// the configuration takes its defaults; the buffer keeps its contents.
// When m_tready is low the result is held; an item is still taken only into
// an empty working stage, and s_tready stays low while that stage is full.
// ----------------------------------------------------------------------------
module char_lcd_tick_controller
  import clcd_pkg::*;
#(
  parameter int BUFFER_DEPTH     = BUFFER_DEPTH_DEF,
  parameter int POWER_ON_WAIT_MS = POWER_ON_WAIT_MS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd[1:0], buf_index[7:2], buf_byte[15:8], str_length[22:16], zero[23]
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // reg_select[0], enable_pin[1], data_pins[9:2], busy_res[10], ready_res[11],
  // accepted[12], zero[15:13]
  output logic [15:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int LW = $clog2(BUFFER_DEPTH + 1);

  cfg_t          cfg;
  item_t         b_item;
  logic          b_valid;
  logic          b_fire;
  logic          s_accept;
  result_t       result;
  result_t       out_data;
  logic          out_valid;
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.four_bit_mode  <= 1'b0;
      cfg.function_flags <= 2'd2;
      cfg.display_flags  <= 3'd4;
      cfg.entry_flags    <= 2'd2;
      cfg.tick_period_ms <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FOUR_BIT: cfg.four_bit_mode  <= cfg_data[0];
        CFG_FUNCTION: cfg.function_flags <= cfg_data[1:0];
        CFG_DISPLAY:  cfg.display_flags  <= cfg_data[2:0];
        CFG_ENTRY:    cfg.entry_flags    <= cfg_data[1:0];
        CFG_TICK:     cfg.tick_period_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign b_fire   = b_valid && (!out_valid || m_tready);
  assign s_tready = !b_valid || b_fire;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (s_accept) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      b_item <= item_t'(s_tdata[22:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_data <= result;
    end
  end

  clcd_buf #(
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW          (AW)
  ) u_buf (
    .clk    (clk),
    .wr_en  (wr_en && b_fire),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (s_accept),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  clcd_core #(
    .BUFFER_DEPTH    (BUFFER_DEPTH),
    .POWER_ON_WAIT_MS(POWER_ON_WAIT_MS),
    .AW              (AW),
    .LW              (LW)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (b_item),
    .step_en(b_fire),
    .rd_data(rd_data),
    .rd_addr(rd_addr),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .result (result)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_data};

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> m_tdata[10])
    else $error("write request taken without busy set");
`endif

endmodule
